// ===== hdl/ubx_pkg.sv =====
// Shared types and constants for the UBX frame receiver.
`default_nettype none
package ubx_pkg;

  // Preamble bytes
  localparam logic [7:0] SyncFirst  = 8'hB5;
  localparam logic [7:0] SyncSecond = 8'h62;

  // Longest payload accepted before a frame is flagged too long
  localparam logic [15:0] MaxPayload = 16'd256;

  // Register reset values
  localparam logic [7:0]  ClassReset   = 8'd6;
  localparam logic [7:0]  IdReset      = 8'd0;
  localparam logic [15:0] TimeoutReset = 16'd200;

  // Configuration register indexes (byte address / 4)
  localparam int unsigned RegAddrWidth = 4;
  localparam logic [1:0] RegClass   = 2'd0;
  localparam logic [1:0] RegId      = 2'd1;
  localparam logic [1:0] RegTimeout = 2'd2;

  // Input opcodes
  localparam logic OpByte = 1'b0;
  localparam logic OpTick = 1'b1;

  // Result kinds
  localparam logic KindPayload  = 1'b0;
  localparam logic KindFrameEnd = 1'b1;

  // Frame end status codes
  localparam logic [1:0] StatOk       = 2'd0;
  localparam logic [1:0] StatBadSum   = 2'd1;
  localparam logic [1:0] StatTimeout  = 2'd2;
  localparam logic [1:0] StatTooLong  = 2'd3;

  // Input word
  typedef struct packed {
    logic       opcode;
    logic [7:0] rx_byte;
  } ubx_in_word_t;

  // Result word
  typedef struct packed {
    logic        kind;
    logic [7:0]  payload_byte;
    logic [15:0] byte_index;
    logic [1:0]  status;
    logic [15:0] frame_length;
  } ubx_out_word_t;

endpackage
`default_nettype wire

// ===== hdl/ubx_if.sv =====
// Valid/ready stream interfaces for the input and result channels.
`default_nettype none
interface ubx_in_if import ubx_pkg::*; ();
  logic         valid;
  logic         ready;
  ubx_in_word_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface ubx_out_if import ubx_pkg::*; ();
  logic          valid;
  logic          ready;
  ubx_out_word_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

// ===== hdl/ubx_frame_receiver.sv =====
// UBX frame receiver: preamble hunt, payload streaming, Fletcher-8 check, timeout.
//
// Takes one word per cycle: a received byte or a time tick. Each word is
// decoded combinationally against the parser state, and any result (a
// payload byte with its index, or a frame end with status) lands in a
// one-deep result register. A new word is taken whenever that register is
// empty or is being drained in the same cycle, so the sustained rate is one
// word per clock; the result register is the only thing that stalls input.
// Configuration registers sit on an APB port at byte addresses 0 (class),
// 4 (id) and 8 (timeout ticks); write them only while the parser is idle.
`default_nettype none
module ubx_frame_receiver import ubx_pkg::*; (
  input  wire logic                    clk,
  input  wire logic                    rst,
  ubx_in_if.sink                       item,
  ubx_out_if.source                    result,
  input  wire logic                    psel,
  input  wire logic                    penable,
  input  wire logic                    pwrite,
  input  wire logic [RegAddrWidth-1:0] paddr,
  input  wire logic [31:0]             pwdata,
  output logic      [31:0]             prdata,
  output logic                         pready
);

  typedef enum logic [8:0] {
    PH_HUNT    = 9'b000000001,
    PH_SYNC2   = 9'b000000010,
    PH_CLASS   = 9'b000000100,
    PH_ID      = 9'b000001000,
    PH_LEN_LO  = 9'b000010000,
    PH_LEN_HI  = 9'b000100000,
    PH_PAYLOAD = 9'b001000000,
    PH_CHECK_A = 9'b010000000,
    PH_CHECK_B = 9'b100000000
  } phase_t;

  // Configuration registers
  logic [7:0]  expected_class;
  logic [7:0]  expected_id;
  logic [15:0] timeout_ticks;

  // Parser state
  phase_t      phase, phase_next;
  logic [7:0]  sum_a, sum_a_next;
  logic [7:0]  sum_b, sum_b_next;
  logic [15:0] length_seen, length_seen_next;
  logic [15:0] bytes_done, bytes_done_next;
  logic [15:0] elapsed_ticks, elapsed_ticks_next;
  logic [7:0]  received_check_a, received_check_a_next;

  // Result register
  logic          out_valid, out_valid_next;
  ubx_out_word_t out_word;

  logic          accept;
  logic          res_fire;
  ubx_out_word_t res_word;
  logic          begin_frame;
  logic [7:0]    rx;
  logic [7:0]    add_a;
  logic [7:0]    add_b;
  logic [15:0]   ticks_inc;
  logic [15:0]   len_full;
  logic [15:0]   done_inc;

  // APB port
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      expected_class <= ClassReset;
      expected_id    <= IdReset;
      timeout_ticks  <= TimeoutReset;
    end else if (psel && penable && pwrite) begin
      case (paddr[3:2])
        RegClass:   expected_class <= pwdata[7:0];
        RegId:      expected_id    <= pwdata[7:0];
        RegTimeout: timeout_ticks  <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      RegClass:   prdata = {24'd0, expected_class};
      RegId:      prdata = {24'd0, expected_id};
      RegTimeout: prdata = {16'd0, timeout_ticks};
      default:    prdata = 32'd0;
    endcase
  end

  // Handshake: take a word when the result register is free or draining
  assign item.ready   = !out_valid || result.ready;
  assign accept       = item.valid && item.ready;
  assign result.valid = out_valid;
  assign result.data  = out_word;

  // Datapath helpers
  assign rx        = item.data.rx_byte;
  assign add_a     = sum_a + rx;
  assign add_b     = sum_b + add_a;
  assign ticks_inc = (elapsed_ticks == 16'hFFFF) ? elapsed_ticks : elapsed_ticks + 16'd1;
  assign len_full  = {rx, length_seen[7:0]};
  assign done_inc  = bytes_done + 16'd1;

  // Next-state and result decode for one word
  always_comb begin
    phase_next            = phase;
    sum_a_next            = sum_a;
    sum_b_next            = sum_b;
    length_seen_next      = length_seen;
    bytes_done_next       = bytes_done;
    elapsed_ticks_next    = elapsed_ticks;
    received_check_a_next = received_check_a;
    res_fire              = 1'b0;
    res_word              = '0;
    begin_frame           = 1'b0;

    if (item.data.opcode == OpTick) begin
      // Ticks only count inside a frame
      if (phase != PH_HUNT) begin
        elapsed_ticks_next = ticks_inc;
        if (ticks_inc >= timeout_ticks) begin
          phase_next            = PH_HUNT;
          res_fire              = 1'b1;
          res_word.kind         = KindFrameEnd;
          res_word.status       = StatTimeout;
          res_word.frame_length = (phase == PH_PAYLOAD || phase == PH_CHECK_A ||
                                   phase == PH_CHECK_B) ? length_seen : 16'd0;
        end
      end
    end else begin
      case (phase)
        PH_HUNT: begin
          begin_frame = (rx == SyncFirst);
        end
        PH_SYNC2: begin
          if (rx == SyncSecond) phase_next = PH_CLASS;
          else begin
            phase_next  = PH_HUNT;
            begin_frame = (rx == SyncFirst);
          end
        end
        PH_CLASS: begin
          if (rx == expected_class) begin
            sum_a_next = add_a;
            sum_b_next = add_b;
            phase_next = PH_ID;
          end else begin
            phase_next  = PH_HUNT;
            begin_frame = (rx == SyncFirst);
          end
        end
        PH_ID: begin
          if (rx == expected_id) begin
            sum_a_next = add_a;
            sum_b_next = add_b;
            phase_next = PH_LEN_LO;
          end else begin
            phase_next  = PH_HUNT;
            begin_frame = (rx == SyncFirst);
          end
        end
        PH_LEN_LO: begin
          sum_a_next       = add_a;
          sum_b_next       = add_b;
          length_seen_next = {8'd0, rx};
          phase_next       = PH_LEN_HI;
        end
        PH_LEN_HI: begin
          sum_a_next       = add_a;
          sum_b_next       = add_b;
          length_seen_next = len_full;
          bytes_done_next  = 16'd0;
          if (len_full > MaxPayload) begin
            phase_next            = PH_HUNT;
            res_fire              = 1'b1;
            res_word.kind         = KindFrameEnd;
            res_word.status       = StatTooLong;
            res_word.frame_length = len_full;
          end else if (len_full == 16'd0) begin
            phase_next = PH_CHECK_A;
          end else begin
            phase_next = PH_PAYLOAD;
          end
        end
        PH_PAYLOAD: begin
          sum_a_next            = add_a;
          sum_b_next            = add_b;
          bytes_done_next       = done_inc;
          res_fire              = 1'b1;
          res_word.kind         = KindPayload;
          res_word.payload_byte = rx;
          res_word.byte_index   = bytes_done;
          res_word.frame_length = length_seen;
          if (done_inc >= length_seen) phase_next = PH_CHECK_A;
        end
        PH_CHECK_A: begin
          received_check_a_next = rx;
          phase_next            = PH_CHECK_B;
        end
        PH_CHECK_B: begin
          phase_next            = PH_HUNT;
          res_fire              = 1'b1;
          res_word.kind         = KindFrameEnd;
          res_word.status       = (received_check_a == sum_a && rx == sum_b) ?
                                  StatOk : StatBadSum;
          res_word.frame_length = length_seen;
        end
        default: begin
          phase_next  = PH_HUNT;
          begin_frame = (rx == SyncFirst);
        end
      endcase

      // First sync byte seen: open a fresh frame
      if (begin_frame) begin
        phase_next            = PH_SYNC2;
        sum_a_next            = 8'd0;
        sum_b_next            = 8'd0;
        length_seen_next      = 16'd0;
        bytes_done_next       = 16'd0;
        elapsed_ticks_next    = 16'd0;
        received_check_a_next = 8'd0;
      end
    end
  end

  // Parser state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      phase            <= PH_HUNT;
      sum_a            <= 8'd0;
      sum_b            <= 8'd0;
      length_seen      <= 16'd0;
      bytes_done       <= 16'd0;
      elapsed_ticks    <= 16'd0;
      received_check_a <= 8'd0;
    end else if (accept) begin
      phase            <= phase_next;
      sum_a            <= sum_a_next;
      sum_b            <= sum_b_next;
      length_seen      <= length_seen_next;
      bytes_done       <= bytes_done_next;
      elapsed_ticks    <= elapsed_ticks_next;
      received_check_a <= received_check_a_next;
    end
  end

  // Result register
  always_comb begin
    if (accept)            out_valid_next = res_fire;
    else if (result.ready) out_valid_next = 1'b0;
    else                   out_valid_next = out_valid;
  end

  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else     out_valid <= out_valid_next;
  end

  always_ff @(posedge clk) begin
    if (accept && res_fire) out_word <= res_word;
  end

endmodule
`default_nettype wire
